@@ rtl/core/fup_pkg.sv @@
// Shared types, constants and lookup tables for the functional unit reservation pool.
package fup_pkg;

   localparam int UNITS_PER_CLASS = 4;
   localparam int CLASS_COUNT     = 22;
   localparam int OPCODE_COUNT    = 61;

   localparam int TABLE_CLASSES = 22;
   localparam int TABLE_OPCODES = 64;

   localparam int CYCLE_W = 32;
   localparam int UOP_W   = 6;
   localparam int LAT_W   = 5;
   localparam int CLS_W   = 5;
   localparam int UIDX_W  = 2;
   localparam int CNT_W   = $clog2(UNITS_PER_CLASS + 1);
   localparam int ROW_W   = UNITS_PER_CLASS * CYCLE_W;

   // Item kinds carried on the opcode field
   localparam logic OP_RESERVE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } fup_state_type;

   typedef struct packed {
      logic load;     // capture the beat and read the class row
      logic commit;   // write back the row and load the result register
   } fup_cmd_type;

   typedef struct packed {
      logic out_room; // result register is empty or being emptied
   } fup_sts_type;

   typedef struct packed {
      logic [2:0]       count;
      logic [LAT_W-1:0] op_lat;
      logic [LAT_W-1:0] issue_lat;
   } class_info_type;

   localparam class_info_type CLASS_INFO [TABLE_CLASSES] = '{
      '{3'd0, 5'd0,  5'd0},
      '{3'd4, 5'd1,  5'd1},  '{3'd2, 5'd2,  5'd2},  '{3'd1, 5'd5,  5'd5},
      '{3'd4, 5'd2,  5'd2},  '{3'd4, 5'd1,  5'd1},
      '{3'd2, 5'd2,  5'd2},  '{3'd2, 5'd5,  5'd5},  '{3'd2, 5'd2,  5'd2},
      '{3'd1, 5'd10, 5'd10}, '{3'd1, 5'd15, 5'd15}, '{3'd1, 5'd20, 5'd20},
      '{3'd1, 5'd1,  5'd1},  '{3'd1, 5'd2,  5'd2},  '{3'd1, 5'd5,  5'd5},
      '{3'd1, 5'd1,  5'd1},
      '{3'd1, 5'd5,  5'd5},  '{3'd1, 5'd2,  5'd2},  '{3'd1, 5'd10, 5'd10},
      '{3'd1, 5'd15, 5'd15}, '{3'd1, 5'd5,  5'd5},  '{3'd1, 5'd20, 5'd20}
   };

   localparam logic [CLS_W-1:0] OPCODE_CLASS [TABLE_OPCODES] = '{
      5'd0,  5'd0,  5'd1,  5'd1,  5'd2,  5'd3,  5'd4,
      5'd5,  5'd5,  5'd5,  5'd5,  5'd5,  5'd5,
      5'd0,  5'd6,  5'd6,
      5'd7,  5'd7,  5'd8,  5'd9,  5'd10,
      5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11,
      5'd0,  5'd0,
      5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15,
      5'd12, 5'd12, 5'd12, 5'd13, 5'd14,
      5'd16, 5'd16, 5'd17, 5'd18, 5'd19,
      5'd21,
      5'd15, 5'd15, 5'd20,
      5'd0,  5'd0,  5'd0,
      5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
      5'd0,
      5'd0,  5'd0,  5'd0
   };

   // Class for a micro-op opcode; 0 means no unit needed
   function automatic logic [CLS_W-1:0] class_of(input logic [UOP_W-1:0] uop);
      logic [CLS_W-1:0] cls;
      cls = OPCODE_CLASS[uop];
      if (32'(uop) >= OPCODE_COUNT || 32'(cls) >= CLASS_COUNT ||
          32'(cls) >= TABLE_CLASSES) begin
         cls = '0;
      end
      return cls;
   endfunction

   // Units usable in a class, limited to what a pool row holds
   function automatic logic [CNT_W-1:0] units_of(input logic [CLS_W-1:0] cls);
      logic [2:0] cnt;
      cnt = CLASS_INFO[cls].count;
      if (32'(cnt) > UNITS_PER_CLASS) begin
         cnt = 3'(UNITS_PER_CLASS);
      end
      return CNT_W'(cnt);
   endfunction

endpackage

@@ rtl/core/fup_ctrl.sv @@
// Controller state machine: sequences row read and commit for each beat.
module fup_ctrl import fup_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  fup_sts_type sts,
   output fup_cmd_type cmd
);

   fup_state_type state_ff;
   fup_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the result register can take the outcome
            if (sts.out_room) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/fup_dpath.sv @@
// Datapath: pool memory, unit selection, free-time update and result register.
module fup_dpath import fup_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  fup_cmd_type        cmd,
   output fup_sts_type        sts,
   input  logic               req_opcode,
   input  logic [UOP_W-1:0]   req_uop_opcode,
   input  logic [CYCLE_W-1:0] req_current_cycle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LAT_W-1:0]   rsp_latency,
   output logic [CLS_W-1:0]   rsp_unit_class,
   output logic [UIDX_W-1:0]  rsp_unit_index
);

   // one row per class, one 32-bit free-at time per unit
   logic [ROW_W-1:0]         pool_mem [TABLE_CLASSES];
   logic [TABLE_CLASSES-1:0] row_valid_ff;

   logic                     op_ff;
   logic [CLS_W-1:0]         cls_ff;
   logic [CYCLE_W-1:0]       now_ff;
   logic [ROW_W-1:0]         row_ff;
   logic                     row_vld_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [LAT_W-1:0]         lat_ff;
   logic [CLS_W-1:0]         ucls_ff;
   logic [UIDX_W-1:0]        uidx_ff;

   logic [CLS_W-1:0]         cls_lookup;
   logic [CYCLE_W-1:0]       free_at [UNITS_PER_CLASS];
   logic [UNITS_PER_CLASS-1:0] hit;
   logic [UIDX_W-1:0]        pick;
   logic [CNT_W-1:0]         cnt;
   logic [CYCLE_W:0]         sum;
   logic [CYCLE_W-1:0]       next_free;
   logic                     grant;
   logic [ROW_W-1:0]         new_row;
   logic [LAT_W-1:0]         lat_in;
   logic [CLS_W-1:0]         ucls_in;
   logic [UIDX_W-1:0]        uidx_in;

   assign cls_lookup = class_of(req_uop_opcode);

   // capture the beat and read its class row
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_opcode;
         cls_ff     <= cls_lookup;
         now_ff     <= req_current_cycle;
         row_ff     <= pool_mem[cls_lookup];
         row_vld_ff <= row_valid_ff[cls_lookup];
      end
   end

   always_comb begin
      cnt = units_of(cls_ff);
      for (int i = 0; i < UNITS_PER_CLASS; i++) begin
         free_at[i] = row_vld_ff ? row_ff[i*CYCLE_W +: CYCLE_W] : '0;
         hit[i]     = (CNT_W'(i) < cnt) && (free_at[i] <= now_ff);
      end
      pick = '0;
      for (int i = UNITS_PER_CLASS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            pick = UIDX_W'(i);
         end
      end
      sum       = {1'b0, now_ff} + (CYCLE_W+1)'(CLASS_INFO[cls_ff].issue_lat);
      next_free = sum[CYCLE_W] ? '1 : sum[CYCLE_W-1:0];
      grant     = (op_ff == OP_RESERVE) && (cls_ff != '0) && (|hit);
      for (int i = 0; i < UNITS_PER_CLASS; i++) begin
         new_row[i*CYCLE_W +: CYCLE_W] = (UIDX_W'(i) == pick) ? next_free : free_at[i];
      end

      lat_in  = '0;
      ucls_in = '0;
      uidx_in = '0;
      if (op_ff == OP_RESERVE) begin
         if (cls_ff == '0) begin
            lat_in = LAT_W'(1);
         end else begin
            ucls_in = cls_ff;
            if (grant) begin
               lat_in  = CLASS_INFO[cls_ff].op_lat;
               uidx_in = pick;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && grant) begin
         pool_mem[cls_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.commit) begin
         if (op_ff == OP_RELEASE) begin
            row_valid_ff <= '0;
         end else if (grant) begin
            row_valid_ff[cls_ff] <= 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         lat_ff  <= lat_in;
         ucls_ff <= ucls_in;
         uidx_ff <= uidx_in;
      end
   end

   assign sts.out_room   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_latency    = lat_ff;
   assign rsp_unit_class = ucls_ff;
   assign rsp_unit_index = uidx_ff;

endmodule

@@ rtl/core/functional_unit_reservation_pool.sv @@
// Top level of the functional unit reservation pool.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_opcode, req_uop_opcode, req_current_cycle
//   rsp      out        rsp_valid/rsp_ready   rsp_latency, rsp_unit_class, rsp_unit_index
//
// Each request beat is handled in order: the load reads its class row from the pool
// memory (one row holds the free-at times of all units of a class), then the commit
// compares the units against the current cycle and writes the row back.
// A result that waits in the output register delays the commit of the next
// beat, but a new request is still taken while that result waits.
// Reset clears the row valid bits; an invalid row reads as all units free, so
// there is no clearing pass. A release beat does the same.
module functional_unit_reservation_pool import fup_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [UOP_W-1:0]   req_uop_opcode,
   input  logic [CYCLE_W-1:0] req_current_cycle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LAT_W-1:0]   rsp_latency,
   output logic [CLS_W-1:0]   rsp_unit_class,
   output logic [UIDX_W-1:0]  rsp_unit_index
);

   fup_cmd_type cmd;
   fup_sts_type sts;

   // sequence load and commit; the datapath only reports result space
   fup_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // pool memory, lowest-free-unit pick and the result register
   fup_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_uop_opcode    (req_uop_opcode),
      .req_current_cycle (req_current_cycle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_latency       (rsp_latency),
      .rsp_unit_class    (rsp_unit_class),
      .rsp_unit_index    (rsp_unit_index)
   );

endmodule

@@ rtl/core/fup_checker.sv @@
// Port-level checks for the functional unit reservation pool, bound to the top level.
module fup_checker import fup_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_opcode,
   input logic [UOP_W-1:0]   req_uop_opcode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [LAT_W-1:0]   rsp_latency,
   input logic [CLS_W-1:0]   rsp_unit_class,
   input logic [UIDX_W-1:0]  rsp_unit_index
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_latency) &&
      $stable(rsp_unit_class) && $stable(rsp_unit_index))
      else $error("rsp payload changed while stalled");

   // one beat at a time: no request taken in the cycle after a beat
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("request taken while previous beat in flight");

   // with the output empty, a release beat reports zeros once it commits
   a_release_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid && (req_opcode == OP_RELEASE) |-> ##2
      (rsp_valid && rsp_latency == '0 && rsp_unit_class == '0 && rsp_unit_index == '0))
      else $error("release beat gave a wrong result");

   // with the output empty, an opcode outside the table reports class zero, as one that needs no unit
   a_no_unit_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid && (req_opcode == OP_RESERVE) &&
      (32'(req_uop_opcode) >= OPCODE_COUNT) |-> ##2
      (rsp_valid && rsp_latency == LAT_W'(1) && rsp_unit_class == '0))
      else $error("unit-free opcode gave a wrong result");

endmodule

bind functional_unit_reservation_pool fup_checker u_fup_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_opcode        (req_opcode),
   .req_uop_opcode    (req_uop_opcode),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_latency       (rsp_latency),
   .rsp_unit_class    (rsp_unit_class),
   .rsp_unit_index    (rsp_unit_index)
);

@@ bench/tb.sv @@
// Self-checking testbench for the functional unit reservation pool.
`timescale 1ns / 100ps

import fup_pkg::*;

typedef struct packed {
   logic [LAT_W-1:0]  latency;
   logic [CLS_W-1:0]  unit_class;
   logic [UIDX_W-1:0] unit_index;
} grant_type;

class unit_grant_checker;
   // class per micro-op opcode; 0 means no unit is needed
   int unsigned uop_class[64] = '{
      0, 0, 1, 1, 2, 3, 4,
      5, 5, 5, 5, 5, 5,
      0, 6, 6,
      7, 7, 8, 9, 10,
      11, 11, 11, 11, 11, 11, 11, 11,
      0, 0,
      15, 15, 15, 15, 15, 15, 15,
      12, 12, 12, 13, 14,
      16, 16, 17, 18, 19,
      21,
      15, 15, 20,
      0, 0, 0, 0, 0, 0, 0, 0, 0,
      0, 0, 0
   };
   int unsigned unit_count[22] = '{
      0, 4, 2, 1, 4, 4, 2, 2, 2, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1
   };
   int unsigned op_latency[22] = '{
      0, 1, 2, 5, 2, 1, 2, 5, 2, 10, 15, 20, 1, 2, 5, 1, 5, 2, 10, 15, 5, 20
   };
   int unsigned issue_latency[22] = '{
      0, 1, 2, 5, 2, 1, 2, 5, 2, 10, 15, 20, 1, 2, 5, 1, 5, 2, 10, 15, 5, 20
   };

   logic [CYCLE_W-1:0] unit_free_at[CLASS_COUNT * UNITS_PER_CLASS];
   grant_type          grants_due[$];
   int mismatches, results_seen;
   int granted, denied, no_unit, releases, saturated;

   function new();
      foreach (unit_free_at[i]) unit_free_at[i] = '0;
   endfunction

   task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) begin
         $display("mismatch at %0t, result %0d: %s", $realtime, results_seen, what);
      end
   endtask

   // Work out the grant for one accepted request and advance the pool copy.
   function void note_request(logic kind, logic [UOP_W-1:0] uop, logic [CYCLE_W-1:0] now);
      grant_type        g;
      int unsigned      cls, units, slot;
      bit               taken;
      logic [CYCLE_W:0] busy_until;
      g = '0;
      taken = 1'b0;
      if (kind == OP_RELEASE) begin
         foreach (unit_free_at[i]) unit_free_at[i] = '0;
         releases++;
      end else begin
         cls = (int'(uop) < OPCODE_COUNT) ? uop_class[uop] : 0;
         if (cls >= CLASS_COUNT) cls = 0;
         if (cls == 0) begin
            g.latency = LAT_W'(1);
            no_unit++;
         end else begin
            g.unit_class = cls[CLS_W-1:0];
            units = (unit_count[cls] > UNITS_PER_CLASS) ? UNITS_PER_CLASS : unit_count[cls];
            for (int u = 0; u < units; u++) begin
               slot = cls * UNITS_PER_CLASS + u;
               if (!taken && unit_free_at[slot] <= now) begin
                  taken = 1'b1;
                  busy_until = {1'b0, now} + (CYCLE_W+1)'(issue_latency[cls]);
                  if (busy_until[CYCLE_W]) saturated++;
                  unit_free_at[slot] = busy_until[CYCLE_W] ? '1 : busy_until[CYCLE_W-1:0];
                  g.latency = LAT_W'(op_latency[cls]);
                  g.unit_index = u[UIDX_W-1:0];
               end
            end
            if (taken) granted++;
            else denied++;
         end
      end
      grants_due.push_back(g);
   endfunction

   task check_grant(logic [LAT_W-1:0] lat, logic [CLS_W-1:0] cls, logic [UIDX_W-1:0] idx);
      grant_type want;
      results_seen++;
      if (grants_due.size() == 0) begin
         report_mismatch($sformatf("unexpected beat latency=%0d class=%0d index=%0d",
                                   lat, cls, idx));
      end else begin
         want = grants_due.pop_front();
         if (lat !== want.latency)
            report_mismatch($sformatf("latency %0d, want %0d", lat, want.latency));
         if (cls !== want.unit_class)
            report_mismatch($sformatf("unit_class %0d, want %0d", cls, want.unit_class));
         if (idx !== want.unit_index)
            report_mismatch($sformatf("unit_index %0d, want %0d", idx, want.unit_index));
      end
   endtask
endclass

module tb;
   localparam int STALL_LIMIT = 5000;

   logic               clock;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic               req_opcode        = OP_RESERVE;
   logic [UOP_W-1:0]   req_uop_opcode    = '0;
   logic [CYCLE_W-1:0] req_current_cycle = '0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic [LAT_W-1:0]   rsp_latency;
   logic [CLS_W-1:0]   rsp_unit_class;
   logic [UIDX_W-1:0]  rsp_unit_index;

   unit_grant_checker  sb = new();

   bit                 source_idles = 1'b1;
   bit                 sink_idles   = 1'b1;
   logic [CYCLE_W-1:0] sim_now      = '0;
   int                 stalled      = 0;

   functional_unit_reservation_pool u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_uop_opcode    (req_uop_opcode),
      .req_current_cycle (req_current_cycle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_latency       (rsp_latency),
      .rsp_unit_class    (rsp_unit_class),
      .rsp_unit_index    (rsp_unit_index)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: drop ready now and then at a falling edge while idling is on.
   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= !(sink_idles && $urandom_range(0, 99) < 13);
      end
   end

   // Observe both channels at the rising edge. A request beat feeds the
   // predictor, a result beat is checked against the oldest grant due.
   // Any beat in either direction resets the stall count.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_opcode, req_uop_opcode, req_current_cycle);
         if (rsp_valid && rsp_ready)
            sb.check_grant(rsp_latency, rsp_unit_class, rsp_unit_index);
         stalled <= ((req_valid && req_ready) || (rsp_valid && rsp_ready)) ? 0 : stalled + 1;
      end
   end

   // Watchdog: end the run if no beat moves for too long.
   initial begin
      while (stalled < STALL_LIMIT) @(posedge clock);
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
   end

   // Present one request beat. Called at a falling edge and returns at the
   // falling edge after the beat is taken; valid stays high in between so a
   // back-to-back beat never lowers and raises it in the same step.
   task automatic send_item(input logic kind, input logic [UOP_W-1:0] uop,
                            input logic [CYCLE_W-1:0] now);
      while (source_idles && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= kind;
      req_uop_opcode    <= uop;
      req_current_cycle <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold the sender until every grant due has come back.
   task automatic drain_grants();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.grants_due.size() != 0);
   endtask

   // One random beat: mostly reserves against a slowly advancing cycle so
   // that units fill up and get denied, with the odd release and jumps in
   // the cycle (backwards too, and right up to the top of the range).
   task automatic random_item();
      int   pick;
      logic kind;
      logic [UOP_W-1:0] uop;
      pick = $urandom_range(0, 99);
      if (pick >= 98) sim_now = 32'hFFFF_FFFF - $urandom_range(0, 24);
      else if (pick >= 96) sim_now = $urandom();
      else if (pick >= 85) sim_now += $urandom_range(4, 25);
      else if (pick >= 55) sim_now += $urandom_range(1, 3);
      kind = ($urandom_range(0, 99) < 3) ? OP_RELEASE : OP_RESERVE;
      uop  = ($urandom_range(0, 3) == 0) ? UOP_W'($urandom_range(0, 63))
                                         : UOP_W'($urandom_range(2, 51));
      send_item(kind, uop, sim_now);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed: release, then opcodes that need no unit at the field extremes
      send_item(OP_RELEASE, 6'd0,  32'd0);
      send_item(OP_RESERVE, 6'd0,  32'd0);
      send_item(OP_RESERVE, 6'd63, 32'hFFFF_FFFF);
      send_item(OP_RESERVE, 6'd60, 32'd0);
      // fill all four units of a wide class, lowest index first, then deny
      // and take unit 0 again once its busy time has passed
      repeat (4) send_item(OP_RESERVE, 6'd2, 32'd200);
      send_item(OP_RESERVE, 6'd2, 32'd200);
      send_item(OP_RESERVE, 6'd2, 32'd201);
      // single-unit class: grant, deny just before the unit is free, grant on the free cycle
      send_item(OP_RESERVE, 6'd5, 32'd100);
      send_item(OP_RESERVE, 6'd5, 32'd104);
      send_item(OP_RESERVE, 6'd5, 32'd105);
      // busy time saturates at the top of the cycle range
      send_item(OP_RESERVE, 6'd48, 32'hFFFF_FFF0);
      send_item(OP_RESERVE, 6'd48, 32'hFFFF_FFFE);
      send_item(OP_RESERVE, 6'd48, 32'hFFFF_FFFF);
      // release frees the saturated unit
      send_item(OP_RELEASE, 6'd63, 32'hFFFF_FFFF);
      send_item(OP_RESERVE, 6'd48, 32'd0);
      // classes are independent of each other
      send_item(OP_RESERVE, 6'd4,  32'd7);
      send_item(OP_RESERVE, 6'd4,  32'd7);
      send_item(OP_RESERVE, 6'd14, 32'd7);
      send_item(OP_RESERVE, 6'd20, 32'h5555_5555);
      send_item(OP_RESERVE, 6'd19, 32'hAAAA_AAAA);
      drain_grants();

      // Random, with idling on both sides
      repeat (400) random_item();
      drain_grants();

      // Random at full rate: no idling either side
      source_idles = 1'b0;
      sink_idles   = 1'b0;
      repeat (250) random_item();
      source_idles = 1'b1;
      sink_idles   = 1'b1;

      repeat (400) random_item();

      // Let the last grants out, then wait on for strays before the final check
      req_valid <= 1'b0;
      while (sb.grants_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (sb.grants_due.size() != 0)
         sb.report_mismatch($sformatf("%0d grants never arrived", sb.grants_due.size()));

      $display("summary: %0d results checked, %0d mismatches", sb.results_seen,
               sb.mismatches);
      $display("summary: %0d granted, %0d denied, %0d no unit, %0d releases, %0d saturated",
               sb.granted, sb.denied, sb.no_unit, sb.releases, sb.saturated);
      if (sb.mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule

@@ files.f @@
rtl/core/fup_pkg.sv
rtl/core/fup_ctrl.sv
rtl/core/fup_dpath.sv
rtl/core/functional_unit_reservation_pool.sv
rtl/core/fup_checker.sv
bench/tb.sv
